[src/lcdst_pkg.sv]
// Package for the LCD scan timing block: constants, register indexes and the result type.
`timescale 1ns / 1ps

package lcdst_pkg;

    localparam int unsigned DotW  = 7;
    localparam int unsigned LineW = 8;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 8;

    localparam logic [DotW-1:0]  DotLast    = 7'd113;
    localparam logic [DotW-1:0]  DotStrobeA = 7'd0;
    localparam logic [DotW-1:0]  DotStrobeB = 7'd7;
    localparam logic [DotW-1:0]  DotStrobeC = 7'd45;
    localparam logic [DotW-1:0]  DotStrobeD = 7'd83;
    localparam logic [LineW-1:0] LineVblank = 8'd144;
    localparam logic [LineW-1:0] LineLast   = 8'd153;

    localparam logic [CfgIdxW-1:0] CfgCompareLine   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgDisplayEnable = 2'd1;

    typedef struct packed {
        logic [DotW-1:0]  dot_count;
        logic [LineW-1:0] line_count;
        logic             line_match;
        logic             vblank_flag;
        logic             line_end_pulse;
        logic             control_pin;
        logic             flip_pin;
        logic             vsync_pin;
        logic             latch_pin;
    } t_result;

endpackage

[src/lcdst_timing.sv]
// Dot and line counters, vertical flags and pin logic, advanced once per accepted item.
`timescale 1ns / 1ps

module lcdst_timing (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic                          i_enable,
    input  logic [lcdst_pkg::LineW-1:0]   i_compare_line,
    input  logic                          i_div7,
    input  logic                          i_div6,
    output lcdst_pkg::t_result            o_result
);

    logic [lcdst_pkg::DotW-1:0]  r_dot,  n_dot;
    logic [lcdst_pkg::LineW-1:0] r_line, n_line;
    logic r_le, n_le, r_del, n_del, r_vb, n_vb, r_fe, n_fe, n_strobe;
    logic r_lpar, n_lpar, r_fpar, n_fpar, r_vsync, n_vsync, n_match;

    always_comb begin
        n_match  = (r_line == i_compare_line);
        n_dot    = '0;
        n_line   = '0;
        n_le     = 1'b0;
        n_del    = 1'b0;
        n_vb     = 1'b0;
        n_fe     = 1'b0;
        n_strobe = 1'b0;
        n_lpar   = 1'b0;
        n_fpar   = 1'b0;
        n_vsync  = 1'b0;
        if (i_enable) begin
            n_le  = (r_dot == lcdst_pkg::DotLast);
            n_del = r_le;
            n_vb  = r_vb;
            n_fe  = r_fe;
            // Vertical flags are sampled on the rise of the delayed line end.
            if (n_del && !r_del) begin
                n_vb = (r_line >= lcdst_pkg::LineVblank);
                n_fe = (r_line == lcdst_pkg::LineLast);
            end
            n_strobe = (r_dot == lcdst_pkg::DotStrobeA) || (r_dot == lcdst_pkg::DotStrobeB) ||
                       (r_dot == lcdst_pkg::DotStrobeC) || (r_dot == lcdst_pkg::DotStrobeD);
            n_dot  = n_le ? '0 : r_dot + 1'b1;
            n_line = (n_le && !r_le) ? r_line + 1'b1 : r_line;
            if (n_fe) begin
                n_line = '0;
            end
            n_lpar  = r_lpar ^ (r_le && !n_le);
            n_fpar  = r_fpar ^ (n_vb && !r_vb);
            n_vsync = (r_del && !n_del) ? (n_line == '0) : r_vsync;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot    <= '0;
            r_line   <= '0;
            r_le     <= 1'b0;
            r_del    <= 1'b0;
            r_vb     <= 1'b0;
            r_fe     <= 1'b0;
            r_lpar   <= 1'b0;
            r_fpar   <= 1'b0;
            r_vsync  <= 1'b0;
        end else if (i_advance) begin
            r_dot    <= n_dot;
            r_line   <= n_line;
            r_le     <= n_le;
            r_del    <= n_del;
            r_vb     <= n_vb;
            r_fe     <= n_fe;
            r_lpar   <= n_lpar;
            r_fpar   <= n_fpar;
            r_vsync  <= n_vsync;
        end
    end

    // The result describes the state after this item, so it is taken from the next values.
    // The strobe and match flags are held in the output register of the top level.
    always_comb begin
        o_result.dot_count      = n_dot;
        o_result.line_count     = n_line;
        o_result.line_match     = n_match;
        o_result.vblank_flag    = n_vb;
        o_result.line_end_pulse = n_le;
        o_result.control_pin    = ~(n_strobe | n_le);
        o_result.flip_pin       = i_enable ? (n_lpar ^ n_fpar) : ~i_div7;
        o_result.vsync_pin      = ~n_vsync;
        o_result.latch_pin      = i_enable ? ~n_le : ~i_div6;
    end

endmodule

[src/lcd_scan_timing_with_line_compare_top.sv]
// Top level of the LCD scan timing generator with line compare.
`timescale 1ns / 1ps

// Usage notes.
// Each input item is one timing tick and carries the two divider bits, which
// only matter while the display is disabled. An item is accepted at a rising
// edge where i_in_valid is high and o_in_stall is low; each item yields exactly
// one result item carrying the counters, flags and pin levels after that tick.
// The counters and flags are updated at the edge that accepts the item, and
// the result sits in an output register, so o_out_valid rises in the cycle
// after acceptance. One item per cycle is sustained while i_out_stall is low:
// the output register is refilled in the same cycle as it is drained.
// When the receiver raises i_out_stall while a result is held, o_in_stall
// goes high and the held result stays unchanged until it is taken.
// Configuration writes (compare line at index 0, display enable at index 1)
// use i_cfg_valid with o_cfg_ready, which is always high; writes to other
// indexes are ignored. Write them only while the block is idle.
// Synchronous reset clears all counters, flags and both registers, and empties
// the output register; the display then starts disabled.

module lcd_scan_timing_with_line_compare_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_divider_bit_seven,
    input  logic                              i_divider_bit_six,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lcdst_pkg::DotW-1:0]        o_dot_count,
    output logic [lcdst_pkg::LineW-1:0]       o_line_count,
    output logic                              o_line_match,
    output logic                              o_vblank_flag,
    output logic                              o_line_end_pulse,
    output logic                              o_control_pin,
    output logic                              o_flip_pin,
    output logic                              o_vsync_pin,
    output logic                              o_latch_pin,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lcdst_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [lcdst_pkg::CfgDataW-1:0]    i_cfg_data
);

    logic [lcdst_pkg::LineW-1:0] r_compare_line;
    logic                        r_display_enable;
    logic                        r_out_valid;
    lcdst_pkg::t_result          r_out;
    lcdst_pkg::t_result          w_result;
    logic                        w_accept;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compare_line   <= '0;
            r_display_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lcdst_pkg::CfgCompareLine: begin
                    r_compare_line <= i_cfg_data[lcdst_pkg::LineW-1:0];
                end
                lcdst_pkg::CfgDisplayEnable: begin
                    r_display_enable <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // The input side only waits when a held result cannot leave this cycle.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    lcdst_timing u_timing (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_accept),
        .i_enable       (r_display_enable),
        .i_compare_line (r_compare_line),
        .i_div7         (i_divider_bit_seven),
        .i_div6         (i_divider_bit_six),
        .o_result       (w_result)
    );

    // Output register: loaded on every accepted item, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_dot_count      = r_out.dot_count;
    assign o_line_count     = r_out.line_count;
    assign o_line_match     = r_out.line_match;
    assign o_vblank_flag    = r_out.vblank_flag;
    assign o_line_end_pulse = r_out.line_end_pulse;
    assign o_control_pin    = r_out.control_pin;
    assign o_flip_pin       = r_out.flip_pin;
    assign o_vsync_pin      = r_out.vsync_pin;
    assign o_latch_pin      = r_out.latch_pin;

endmodule

[tb/tb_lcd_scan_timing_with_line_compare_top.sv]
// Self-checking testbench for the LCD scan timing generator with line compare.
`timescale 1ns / 1ps

module tb_lcd_scan_timing_with_line_compare_top;

    // Index values that the block must ignore; writing them checks the decode.
    localparam logic [lcdst_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
    localparam logic [lcdst_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

    // Ticks in one whole line: 114 dots.
    localparam int unsigned LineTicks = 114;

    // Cycles without any accepted item before the run is declared hung.
    localparam int unsigned HangLimit = 3000;

    // Stimulus and clocking. Every input has a known value from time zero.
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           i_divider_bit_seven = 1'b0;
    logic                           i_divider_bit_six = 1'b0;
    logic                           i_out_stall = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic [lcdst_pkg::CfgIdxW-1:0]  i_cfg_index = '0;
    logic [lcdst_pkg::CfgDataW-1:0] i_cfg_data = '0;

    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [lcdst_pkg::DotW-1:0]     o_dot_count;
    logic [lcdst_pkg::LineW-1:0]    o_line_count;
    logic                           o_line_match;
    logic                           o_vblank_flag;
    logic                           o_line_end_pulse;
    logic                           o_control_pin;
    logic                           o_flip_pin;
    logic                           o_vsync_pin;
    logic                           o_latch_pin;
    logic                           o_cfg_ready;

    always #6 i_clk = ~i_clk;

    lcd_scan_timing_with_line_compare_top uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_divider_bit_seven (i_divider_bit_seven),
        .i_divider_bit_six   (i_divider_bit_six),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_dot_count         (o_dot_count),
        .o_line_count        (o_line_count),
        .o_line_match        (o_line_match),
        .o_vblank_flag       (o_vblank_flag),
        .o_line_end_pulse    (o_line_end_pulse),
        .o_control_pin       (o_control_pin),
        .o_flip_pin          (o_flip_pin),
        .o_vsync_pin         (o_vsync_pin),
        .o_latch_pin         (o_latch_pin),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int unsigned send_idle_pct = 9;
    int unsigned recv_stall_pct = 83;

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    bit          cfg_held = 1'b0;

    // Results predicted for accepted ticks, oldest first.
    lcdst_pkg::t_result pending_scan_q[$];

    // Shadow of the configuration registers.
    logic [lcdst_pkg::LineW-1:0] shadow_compare_line;
    logic                        shadow_display_on;

    // Shadow of the scan timing state.
    logic [lcdst_pkg::DotW-1:0]  scan_dot;
    logic [lcdst_pkg::LineW-1:0] scan_line;
    logic                        scan_line_end;
    logic                        scan_line_end_dly;
    logic                        scan_vblank;
    logic                        scan_frame_end;
    logic                        scan_strobe;
    logic                        scan_line_parity;
    logic                        scan_frame_parity;
    logic                        scan_vsync;
    logic                        scan_match;

    // Clears every timing register; the match flag and the registers are kept.
    function automatic void clear_scan_timing();
        scan_dot          = '0;
        scan_line         = '0;
        scan_line_end     = 1'b0;
        scan_line_end_dly = 1'b0;
        scan_vblank       = 1'b0;
        scan_frame_end    = 1'b0;
        scan_strobe       = 1'b0;
        scan_line_parity  = 1'b0;
        scan_frame_parity = 1'b0;
        scan_vsync        = 1'b0;
    endfunction

    // Advances the shadow state by one tick and returns the pin and counter
    // levels that the block should present for that tick.
    function automatic lcdst_pkg::t_result advance_scan(input logic div_seven,
                                                        input logic div_six);
        logic [lcdst_pkg::LineW-1:0] prev_line;
        logic [lcdst_pkg::DotW-1:0]  prev_dot;
        logic                        prev_end;
        logic                        prev_end_dly;
        logic                        prev_vblank;
        logic                        next_end;
        logic                        next_end_dly;
        lcdst_pkg::t_result          res;

        prev_line  = scan_line;
        // The compare looks at the line count from before this tick, even when disabled.
        scan_match = (prev_line == shadow_compare_line);

        if (!shadow_display_on) begin
            clear_scan_timing();
        end else begin
            prev_dot     = scan_dot;
            prev_end     = scan_line_end;
            prev_end_dly = scan_line_end_dly;
            prev_vblank  = scan_vblank;
            next_end     = (prev_dot == lcdst_pkg::DotLast);
            next_end_dly = prev_end;

            // Vblank and frame end are sampled on the rise of the delayed line end.
            if (next_end_dly && !prev_end_dly) begin
                scan_vblank    = (prev_line >= lcdst_pkg::LineVblank);
                scan_frame_end = (prev_line == lcdst_pkg::LineLast);
            end

            scan_strobe = (prev_dot inside {lcdst_pkg::DotStrobeA, lcdst_pkg::DotStrobeB,
                                            lcdst_pkg::DotStrobeC, lcdst_pkg::DotStrobeD});

            scan_line_end     = next_end;
            scan_line_end_dly = next_end_dly;
            scan_dot          = next_end ? '0 : prev_dot + 1'b1;

            if (next_end && !prev_end) begin
                scan_line = prev_line + 1'b1;
            end
            if (scan_frame_end) begin
                scan_line = '0;
            end

            if (prev_end && !next_end) begin
                scan_line_parity = ~scan_line_parity;
            end
            if (scan_vblank && !prev_vblank) begin
                scan_frame_parity = ~scan_frame_parity;
            end

            // Vsync takes the line-zero state on the fall of the delayed line end.
            if (prev_end_dly && !next_end_dly) begin
                scan_vsync = (scan_line == '0);
            end
        end

        res.dot_count      = scan_dot;
        res.line_count     = scan_line;
        res.line_match     = scan_match;
        res.vblank_flag    = scan_vblank;
        res.line_end_pulse = scan_line_end;
        res.control_pin    = ~(scan_strobe | scan_line_end);
        res.vsync_pin      = ~scan_vsync;
        if (shadow_display_on) begin
            res.flip_pin  = scan_line_parity ^ scan_frame_parity;
            res.latch_pin = ~scan_line_end;
        end else begin
            res.flip_pin  = ~div_seven;
            res.latch_pin = ~div_six;
        end
        return res;
    endfunction

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Every result taken from the block is compared with the oldest prediction.
    always @(posedge i_clk) begin
        lcdst_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_scan_q.size() == 0) begin
                $error("result item arrived with no prediction outstanding");
                mismatch_count++;
            end else begin
                want = pending_scan_q.pop_front();
                check_field("dot_count", 32'(want.dot_count), 32'(o_dot_count));
                check_field("line_count", 32'(want.line_count), 32'(o_line_count));
                check_field("line_match", 32'(want.line_match), 32'(o_line_match));
                check_field("vblank_flag", 32'(want.vblank_flag), 32'(o_vblank_flag));
                check_field("line_end_pulse", 32'(want.line_end_pulse),
                            32'(o_line_end_pulse));
                check_field("control_pin", 32'(want.control_pin), 32'(o_control_pin));
                check_field("flip_pin", 32'(want.flip_pin), 32'(o_flip_pin));
                check_field("vsync_pin", 32'(want.vsync_pin), 32'(o_vsync_pin));
                check_field("latch_pin", 32'(want.latch_pin), 32'(o_latch_pin));
            end
        end
    end

    // Watchdog: any accepted item on any channel restarts the count, so only a
    // genuine hang can run it out.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HangLimit) begin
            $display("** lcd_scan_timing_with_line_compare_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // A write leaves its valid high so that back-to-back writes need no gap;
    // the first action that is not a write lowers it again.
    task automatic release_cfg();
        if (cfg_held) begin
            i_cfg_valid <= 1'b0;
            cfg_held = 1'b0;
        end
    endtask

    task automatic write_reg(input logic [lcdst_pkg::CfgIdxW-1:0] idx,
                             input logic [lcdst_pkg::CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_held = 1'b1;
        case (idx)
            lcdst_pkg::CfgCompareLine:   shadow_compare_line = data;
            lcdst_pkg::CfgDisplayEnable: shadow_display_on = data[0];
            default: ;
        endcase
    endtask

    // Sends one tick, with random hold-offs before it, and records its prediction.
    task automatic send_tick(input logic div_seven, input logic div_six);
        release_cfg();
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_divider_bit_seven <= div_seven;
        i_divider_bit_six   <= div_six;
        do @(posedge i_clk); while (o_in_stall);
        pending_scan_q.push_back(advance_scan(div_seven, div_six));
    endtask

    // Holds the sender back until every predicted result has been taken, so
    // that the block is idle for a register write.
    task automatic wait_drained();
        release_cfg();
        i_in_valid <= 1'b0;
        while (pending_scan_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_random_ticks(input int unsigned count);
        repeat (count) begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    // With the display off, the flip and latch pins must follow the inverted
    // divider bits, the counters must stay cleared, and the compare still runs
    // against line zero. Writes to the spare indexes must change nothing.
    task automatic test_disabled_pins();
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        wait_drained();
        write_reg(lcdst_pkg::CfgCompareLine, 8'hFF);
        write_reg(CfgSpareA, 8'hFF);
        write_reg(CfgSpareB, 8'h00);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    // The first dots of a line after enabling: control strobes at dots 0 and 7,
    // and the match flag against line zero. Only bit 0 of the enable write counts.
    task automatic test_strobe_dots();
        wait_drained();
        write_reg(lcdst_pkg::CfgCompareLine, 8'h00);
        write_reg(lcdst_pkg::CfgDisplayEnable, 8'hFF);
        send_random_ticks(16);
    endtask

    // Runs of random length with a fresh setting between runs: the compare line
    // at its extremes, at random and at the current line, and the display
    // switched off and on again.
    task automatic test_random_runs(input int unsigned count);
        int unsigned sent;
        int unsigned run_len;
        logic [lcdst_pkg::CfgDataW-1:0] data;
        sent = 0;
        while (sent < count) begin
            wait_drained();
            case ($urandom_range(3))
                0: begin
                    case ($urandom_range(3))
                        0: data = 8'h00;
                        1: data = 8'hFF;
                        2: data = lcdst_pkg::CfgDataW'($urandom_range(153));
                        default: data = lcdst_pkg::CfgDataW'(scan_line + $urandom_range(1));
                    endcase
                    write_reg(lcdst_pkg::CfgCompareLine, data);
                end
                1: begin
                    // Mostly enabled, so that the counters get somewhere.
                    data    = lcdst_pkg::CfgDataW'($urandom_range(255));
                    data[0] = ($urandom_range(99) < 80);
                    write_reg(lcdst_pkg::CfgDisplayEnable, data);
                end
                2: begin
                    write_reg(lcdst_pkg::CfgCompareLine,
                              lcdst_pkg::CfgDataW'($urandom_range(255)));
                    write_reg(lcdst_pkg::CfgDisplayEnable, 8'h01);
                end
                default: ;
            endcase
            run_len = $urandom_range(250, 1);
            if (run_len > count - sent) begin
                run_len = count - sent;
            end
            send_random_ticks(run_len);
            sent += run_len;
        end
    endtask

    // Just over two whole lines: the line end that advances the line count, the
    // compare match on line one, both line parity edges and vsync at the fall
    // of the delayed line end. The scan then stops, the display is switched
    // off and on again, and the scan restarts from cleared state.
    task automatic test_line_ends();
        wait_drained();
        write_reg(lcdst_pkg::CfgCompareLine, 8'd1);
        write_reg(lcdst_pkg::CfgDisplayEnable, 8'h01);
        send_random_ticks(2 * LineTicks + 10);
        wait_drained();
        write_reg(lcdst_pkg::CfgDisplayEnable, 8'h00);
        send_random_ticks(3);
        wait_drained();
        write_reg(lcdst_pkg::CfgDisplayEnable, 8'h01);
        send_random_ticks(20);
    endtask

    initial begin
        shadow_compare_line = '0;
        shadow_display_on   = 1'b0;
        scan_match          = 1'b0;
        clear_scan_timing();

        // Reset is held low from time zero and released at a rising edge.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First phase: the sender rarely idles, the receiver stalls most cycles.
        send_idle_pct  = 9;
        recv_stall_pct = 83;
        test_disabled_pins();
        test_strobe_dots();
        test_random_runs(570);

        // Second phase: the sender idles most cycles, the receiver rarely stalls.
        send_idle_pct  = 83;
        recv_stall_pct = 9;
        test_random_runs(570);

        // Third phase: full rate on both sides.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_runs(570);
        test_line_ends();

        wait_drained();
        repeat (2) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("** lcd_scan_timing_with_line_compare_top: PASSED **");
        end else begin
            $display("** lcd_scan_timing_with_line_compare_top: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
src/lcdst_pkg.sv
src/lcdst_timing.sv
src/lcd_scan_timing_with_line_compare_top.sv
tb/tb_lcd_scan_timing_with_line_compare_top.sv
